FILE: hdl/event_rotation_warp_second_order_assert.svh
// Assertion macros for the second-order rotational event warp.
`ifndef EVENT_ROTATION_WARP_SECOND_ORDER_ASSERT_SVH
`define EVENT_ROTATION_WARP_SECOND_ORDER_ASSERT_SVH

`define ERW2_ASSERT_NEXT(name, cond, expr, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (cond) |=> (expr)) \
      else $error(msg);

`define ERW2_ASSERT_NOW(name, cond, expr, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (cond) |-> (expr)) \
      else $error(msg);

`endif

FILE: hdl/erw2_pkg.sv
// Shared widths, types and constants of the second-order rotational event warp.
package erw2_pkg;

   localparam int COORD_WIDTH = 16;
   localparam int TIME_WIDTH  = 20;
   localparam int OMEGA_WIDTH = 16;
   localparam int OMEGA_FRAC  = 10;
   localparam int TIME_FRAC   = 20;
   localparam int FINAL_SHIFT = OMEGA_FRAC + TIME_FRAC + 1;

   localparam int C1_WIDTH    = OMEGA_WIDTH + COORD_WIDTH + 1;
   localparam int C2_WIDTH    = OMEGA_WIDTH + C1_WIDTH + 1;
   localparam int C2R_WIDTH   = C2_WIDTH - OMEGA_FRAC;
   localparam int SQ_WIDTH    = 2 * TIME_WIDTH;
   localparam int D2_WIDTH    = TIME_WIDTH + 1;
   localparam int T1_WIDTH    = C1_WIDTH + TIME_WIDTH + 1;
   localparam int PP_SPLIT    = C2R_WIDTH / 2 - 1;
   localparam int PP_LO_WIDTH = PP_SPLIT + D2_WIDTH;
   localparam int PP_HI_WIDTH = C2R_WIDTH - PP_SPLIT + D2_WIDTH + 1;
   localparam int SUM_WIDTH   = 64;
   localparam int ROUND_WIDTH = SUM_WIDTH - FINAL_SHIFT;

   localparam int PIPE_DEPTH  = 5;

   localparam int CSR_INDEX_WIDTH = 2;
   localparam int CSR_DATA_WIDTH  = (TIME_WIDTH > OMEGA_WIDTH) ? TIME_WIDTH : OMEGA_WIDTH;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_OMEGA_X  = 2'd0,
      CSR_OMEGA_Y  = 2'd1,
      CSR_OMEGA_Z  = 2'd2,
      CSR_FIXED_DT = 2'd3
   } csr_index_type;

   typedef logic signed [COORD_WIDTH-1:0] coord_type;
   typedef logic signed [OMEGA_WIDTH-1:0] omega_type;
   typedef logic        [TIME_WIDTH-1:0]  time_type;
   typedef logic signed [C1_WIDTH-1:0]    c1_type;
   typedef logic signed [C2_WIDTH-1:0]    c2_type;
   typedef logic signed [C2R_WIDTH-1:0]   c2r_type;
   typedef logic        [SQ_WIDTH-1:0]    sq_type;
   typedef logic        [D2_WIDTH-1:0]    d2_type;
   typedef logic signed [T1_WIDTH-1:0]    t1_type;
   typedef logic        [PP_LO_WIDTH-1:0] pp_lo_type;
   typedef logic signed [PP_HI_WIDTH-1:0] pp_hi_type;
   typedef logic signed [SUM_WIDTH-1:0]   sum_type;
   typedef logic signed [ROUND_WIDTH-1:0] round_type;

   localparam c2_type    C2_HALF   = C2_WIDTH'(1) <<< (OMEGA_FRAC - 1);
   localparam sq_type    SQ_HALF   = SQ_WIDTH'(1) << (TIME_FRAC - 1);
   localparam sum_type   SUM_HALF  = SUM_WIDTH'(1) <<< (FINAL_SHIFT - 1);
   localparam coord_type COORD_POS = coord_type'((1 << (COORD_WIDTH - 1)) - 1);
   localparam coord_type COORD_NEG = coord_type'(-(1 << (COORD_WIDTH - 1)));
   localparam round_type ROUND_POS = ROUND_WIDTH'(COORD_POS);
   localparam round_type ROUND_NEG = ROUND_WIDTH'(COORD_NEG);

endpackage

FILE: hdl/erw2_front.sv
// Front pipeline: first and second cross products, time square and first-order term.
module erw2_front (
   input  logic                clock,
   input  logic                advance,
   input  erw2_pkg::coord_type in_coord [3],
   input  erw2_pkg::time_type  in_dt,
   input  erw2_pkg::omega_type omega [3],
   output erw2_pkg::c2r_type   c2r [3],
   output erw2_pkg::t1_type    t1 [3],
   output erw2_pkg::d2_type    d2,
   output erw2_pkg::coord_type coord [3]
);
   import erw2_pkg::*;

   c1_type    c1_in [3];
   c1_type    c1_ff [3];
   time_type  dt1_ff;
   coord_type p1_ff [3];

   c2_type    c2_in [3];
   c2_type    c2_ff [3];
   t1_type    t1_in [3];
   t1_type    t1_ff [3];
   sq_type    sq_in;
   sq_type    sq_ff;
   coord_type p2_ff [3];

   c2r_type   c2r_in [3];
   c2r_type   c2r_ff [3];
   d2_type    d2_in;
   d2_type    d2_ff;
   t1_type    t1b_ff [3];
   coord_type p3_ff [3];

   always_comb begin
      c1_in[0] = C1_WIDTH'(omega[1]) * C1_WIDTH'(in_coord[2])
               - C1_WIDTH'(omega[2]) * C1_WIDTH'(in_coord[1]);
      c1_in[1] = C1_WIDTH'(omega[2]) * C1_WIDTH'(in_coord[0])
               - C1_WIDTH'(omega[0]) * C1_WIDTH'(in_coord[2]);
      c1_in[2] = C1_WIDTH'(omega[0]) * C1_WIDTH'(in_coord[1])
               - C1_WIDTH'(omega[1]) * C1_WIDTH'(in_coord[0]);
   end

   always_comb begin
      c2_in[0] = C2_WIDTH'(omega[1]) * C2_WIDTH'(c1_ff[2])
               - C2_WIDTH'(omega[2]) * C2_WIDTH'(c1_ff[1]);
      c2_in[1] = C2_WIDTH'(omega[2]) * C2_WIDTH'(c1_ff[0])
               - C2_WIDTH'(omega[0]) * C2_WIDTH'(c1_ff[2]);
      c2_in[2] = C2_WIDTH'(omega[0]) * C2_WIDTH'(c1_ff[1])
               - C2_WIDTH'(omega[1]) * C2_WIDTH'(c1_ff[0]);
      for (int i = 0; i < 3; i++) begin
         t1_in[i] = T1_WIDTH'(c1_ff[i]) * T1_WIDTH'($signed({1'b0, dt1_ff}));
      end
      sq_in = SQ_WIDTH'(dt1_ff) * SQ_WIDTH'(dt1_ff);
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         c2r_in[i] = C2R_WIDTH'((c2_ff[i] + C2_HALF) >>> OMEGA_FRAC);
      end
      d2_in = D2_WIDTH'((sq_ff + SQ_HALF) >> TIME_FRAC);
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         c1_ff  <= c1_in;
         dt1_ff <= in_dt;
         p1_ff  <= in_coord;
         c2_ff  <= c2_in;
         t1_ff  <= t1_in;
         sq_ff  <= sq_in;
         p2_ff  <= p1_ff;
         c2r_ff <= c2r_in;
         d2_ff  <= d2_in;
         t1b_ff <= t1_ff;
         p3_ff  <= p2_ff;
      end
   end

   assign c2r   = c2r_ff;
   assign t1    = t1b_ff;
   assign d2    = d2_ff;
   assign coord = p3_ff;

endmodule

FILE: hdl/erw2_lane.sv
// Back pipeline of one component: second-order product, final sum, rounding and saturation.
module erw2_lane (
   input  logic                clock,
   input  logic                advance,
   input  erw2_pkg::c2r_type   c2r,
   input  erw2_pkg::t1_type    t1,
   input  erw2_pkg::d2_type    d2,
   input  erw2_pkg::coord_type coord,
   output erw2_pkg::coord_type warped,
   output logic                clip
);
   import erw2_pkg::*;

   pp_lo_type pp_lo_in;
   pp_lo_type pp_lo_ff;
   pp_hi_type pp_hi_in;
   pp_hi_type pp_hi_ff;
   t1_type    t1_ff;
   coord_type p_ff;
   sum_type   sum_in;
   sum_type   sum_ff;
   round_type rnd;

   always_comb begin
      pp_lo_in = PP_LO_WIDTH'(c2r[PP_SPLIT-1:0]) * PP_LO_WIDTH'(d2);
      pp_hi_in = PP_HI_WIDTH'($signed(c2r[C2R_WIDTH-1:PP_SPLIT]))
               * PP_HI_WIDTH'($signed({1'b0, d2}));
   end

   always_comb begin
      sum_in = (SUM_WIDTH'(t1_ff) <<< 1)
             + (SUM_WIDTH'(pp_hi_ff) <<< PP_SPLIT)
             + $signed(SUM_WIDTH'(pp_lo_ff))
             + (SUM_WIDTH'(p_ff) <<< FINAL_SHIFT);
   end

   always_comb begin
      rnd = ROUND_WIDTH'((sum_ff + SUM_HALF) >>> FINAL_SHIFT);
      if (rnd > ROUND_POS) begin
         warped = COORD_POS;
         clip   = 1'b1;
      end else if (rnd < ROUND_NEG) begin
         warped = COORD_NEG;
         clip   = 1'b1;
      end else begin
         warped = COORD_WIDTH'(rnd);
         clip   = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         pp_lo_ff <= pp_lo_in;
         pp_hi_ff <= pp_hi_in;
         t1_ff    <= t1;
         p_ff     <= coord;
         sum_ff   <= sum_in;
      end
   end

endmodule

FILE: hdl/event_rotation_warp_second_order.sv
// Top level of the second-order rotational event warp: handshake, registers and output stage.
// An input transfer passes through the front and lane pipeline registers and the output register before the rsp_ port.
// Throughput: one event per cycle; the whole pipeline holds while the result is not taken.
// The six 16x16 and six 16x33 multipliers of the two cross products set the stage split.
// Synchronous active-high reset clears the velocity and fixed time registers and all valid bits.
`include "event_rotation_warp_second_order_assert.svh"
module event_rotation_warp_second_order (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  erw2_pkg::coord_type               req_coord_x,
   input  erw2_pkg::coord_type               req_coord_y,
   input  erw2_pkg::coord_type               req_coord_z,
   input  erw2_pkg::time_type                req_event_dt,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output erw2_pkg::coord_type               rsp_warped_x,
   output erw2_pkg::coord_type               rsp_warped_y,
   output erw2_pkg::coord_type               rsp_warped_z,
   output logic                              rsp_clipped,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [erw2_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [erw2_pkg::CSR_DATA_WIDTH-1:0]  csr_data
);
   import erw2_pkg::*;

   omega_type omega_ff [3];
   time_type  fixed_dt_ff;

   logic                  advance;
   logic [PIPE_DEPTH-1:0] valid_ff;
   logic                  rsp_valid_ff;
   coord_type             warped_ff [3];
   logic                  clip_ff;
   logic                  at_limit;

   coord_type in_coord [3];
   time_type  in_dt;
   c2r_type   c2r [3];
   t1_type    t1 [3];
   d2_type    d2;
   coord_type coord [3];
   coord_type warped [3];
   logic      clip [3];

   assign csr_ready = !reset;

   always_ff @(posedge clock) begin
      if (reset) begin
         omega_ff    <= '{default: '0};
         fixed_dt_ff <= '0;
      end else if (csr_valid) begin
         unique case (csr_index_type'(csr_index))
            CSR_OMEGA_X:  omega_ff[0] <= OMEGA_WIDTH'(csr_data);
            CSR_OMEGA_Y:  omega_ff[1] <= OMEGA_WIDTH'(csr_data);
            CSR_OMEGA_Z:  omega_ff[2] <= OMEGA_WIDTH'(csr_data);
            CSR_FIXED_DT: fixed_dt_ff <= TIME_WIDTH'(csr_data);
            default:      fixed_dt_ff <= fixed_dt_ff;
         endcase
      end
   end

   assign advance   = !rsp_valid_ff || rsp_ready;
   assign req_ready = advance && !reset;

   assign in_coord[0] = req_coord_x;
   assign in_coord[1] = req_coord_y;
   assign in_coord[2] = req_coord_z;
   assign in_dt       = (fixed_dt_ff != '0) ? fixed_dt_ff : req_event_dt;

   erw2_front u_front (
      .clock    (clock),
      .advance  (advance),
      .in_coord (in_coord),
      .in_dt    (in_dt),
      .omega    (omega_ff),
      .c2r      (c2r),
      .t1       (t1),
      .d2       (d2),
      .coord    (coord)
   );

   for (genvar g = 0; g < 3; g++) begin : g_lane
      erw2_lane u_lane (
         .clock   (clock),
         .advance (advance),
         .c2r     (c2r[g]),
         .t1      (t1[g]),
         .d2      (d2),
         .coord   (coord[g]),
         .warped  (warped[g]),
         .clip    (clip[g])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff     <= {valid_ff[PIPE_DEPTH-2:0], req_valid};
         rsp_valid_ff <= valid_ff[PIPE_DEPTH-1];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         warped_ff <= warped;
         clip_ff   <= clip[0] | clip[1] | clip[2];
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_warped_x = warped_ff[0];
   assign rsp_warped_y = warped_ff[1];
   assign rsp_warped_z = warped_ff[2];
   assign rsp_clipped  = clip_ff;

   assign at_limit = (warped_ff[0] == COORD_POS) || (warped_ff[0] == COORD_NEG)
                  || (warped_ff[1] == COORD_POS) || (warped_ff[1] == COORD_NEG)
                  || (warped_ff[2] == COORD_POS) || (warped_ff[2] == COORD_NEG);

   `ERW2_ASSERT_NEXT(a_accept_enters, req_valid && req_ready, valid_ff[0], "accepted transfer lost at pipeline entry")
   `ERW2_ASSERT_NEXT(a_stall_holds, rsp_valid_ff && !rsp_ready, rsp_valid_ff && $stable(valid_ff), "pipeline moved during stall")
   `ERW2_ASSERT_NOW(a_clip_limit, rsp_valid_ff && rsp_clipped, at_limit, "clipped flag without saturated component")

endmodule

FILE: verif/tb_event_rotation_warp_second_order.sv
// Self-checking testbench for the second-order rotational event warp.
`timescale 1ns / 1ps
module tb_event_rotation_warp_second_order;
   import erw2_pkg::*;

   localparam int       CYCLE_LIMIT = 1000000;
   localparam time_type DT_MAX      = '1;

   typedef struct {
      coord_type warped_x;
      coord_type warped_y;
      coord_type warped_z;
      logic      clipped;
   } warp_result_type;

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       req_valid = 1'b0;
   logic                       req_ready;
   coord_type                  req_coord_x = '0;
   coord_type                  req_coord_y = '0;
   coord_type                  req_coord_z = '0;
   time_type                   req_event_dt = '0;
   logic                       rsp_valid;
   logic                       rsp_ready = 1'b0;
   coord_type                  rsp_warped_x;
   coord_type                  rsp_warped_y;
   coord_type                  rsp_warped_z;
   logic                       rsp_clipped;
   logic                       csr_valid = 1'b0;
   logic                       csr_ready;
   logic [CSR_INDEX_WIDTH-1:0] csr_index = '0;
   logic [CSR_DATA_WIDTH-1:0]  csr_data = '0;

   omega_type omega_x_q = '0;
   omega_type omega_y_q = '0;
   omega_type omega_z_q = '0;
   time_type  fixed_dt_q = '0;

   warp_result_type pending_warps[$];
   int              mismatches = 0;
   int              cycle_count = 0;
   int              rsp_hold = 0;
   bit              idle_enable = 1'b1;

   event_rotation_warp_second_order uut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_coord_x(req_coord_x),
      .req_coord_y(req_coord_y),
      .req_coord_z(req_coord_z),
      .req_event_dt(req_event_dt),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_warped_x(rsp_warped_x),
      .rsp_warped_y(rsp_warped_y),
      .rsp_warped_z(rsp_warped_z),
      .rsp_clipped(rsp_clipped),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_data(csr_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("event_rotation_warp_second_order regression: fail");
         $finish;
      end
   end

   function automatic int pick_gap();
      int roll;
      if (!idle_enable) return 0;
      roll = $urandom_range(0, 99);
      if (roll < 55) return 0;
      if (roll < 93) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   always @(posedge clock) begin
      if (rsp_hold > 0) begin
         rsp_hold <= rsp_hold - 1;
         rsp_ready <= 1'b0;
      end else if (idle_enable && $urandom_range(0, 3) == 0) begin
         rsp_hold <= pick_gap();
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   function automatic warp_result_type predict_warp(coord_type px, coord_type py,
                                                    coord_type pz, time_type edt);
      longint          w[3];
      longint          p[3];
      longint          c1[3];
      longint          c2[3];
      longint          dt;
      longint          d2;
      longint          c2r;
      longint          acc;
      longint          rounded;
      coord_type       comp[3];
      warp_result_type res;
      w[0] = omega_x_q;
      w[1] = omega_y_q;
      w[2] = omega_z_q;
      p[0] = px;
      p[1] = py;
      p[2] = pz;
      dt = (fixed_dt_q != '0) ? longint'(fixed_dt_q) : longint'(edt);
      c1[0] = w[1] * p[2] - w[2] * p[1];
      c1[1] = w[2] * p[0] - w[0] * p[2];
      c1[2] = w[0] * p[1] - w[1] * p[0];
      c2[0] = w[1] * c1[2] - w[2] * c1[1];
      c2[1] = w[2] * c1[0] - w[0] * c1[2];
      c2[2] = w[0] * c1[1] - w[1] * c1[0];
      d2 = (dt * dt + (longint'(1) <<< (TIME_FRAC - 1))) >>> TIME_FRAC;
      res.clipped = 1'b0;
      for (int i = 0; i < 3; i++) begin
         c2r = (c2[i] + (longint'(1) <<< (OMEGA_FRAC - 1))) >>> OMEGA_FRAC;
         acc = ((c1[i] * dt) <<< 1) + c2r * d2 + (p[i] <<< FINAL_SHIFT);
         rounded = (acc + (longint'(1) <<< (FINAL_SHIFT - 1))) >>> FINAL_SHIFT;
         if (rounded > longint'(COORD_POS)) begin
            comp[i] = COORD_POS;
            res.clipped = 1'b1;
         end else if (rounded < longint'(COORD_NEG)) begin
            comp[i] = COORD_NEG;
            res.clipped = 1'b1;
         end else begin
            comp[i] = coord_type'(rounded);
         end
      end
      res.warped_x = comp[0];
      res.warped_y = comp[1];
      res.warped_z = comp[2];
      return res;
   endfunction

   always @(posedge clock) begin
      warp_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_warps.size() == 0) begin
            $error("result transfer with no event outstanding");
            mismatches++;
         end else begin
            want = pending_warps.pop_front();
            if (rsp_warped_x !== want.warped_x) begin
               $error("warped_x mismatch: expected %0d, got %0d", want.warped_x, rsp_warped_x);
               mismatches++;
            end
            if (rsp_warped_y !== want.warped_y) begin
               $error("warped_y mismatch: expected %0d, got %0d", want.warped_y, rsp_warped_y);
               mismatches++;
            end
            if (rsp_warped_z !== want.warped_z) begin
               $error("warped_z mismatch: expected %0d, got %0d", want.warped_z, rsp_warped_z);
               mismatches++;
            end
            if (rsp_clipped !== want.clipped) begin
               $error("clipped mismatch: expected %0d, got %0d", want.clipped, rsp_clipped);
               mismatches++;
            end
         end
      end
   end

   task automatic send_event(coord_type px, coord_type py, coord_type pz, time_type edt);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_coord_x <= px;
      req_coord_y <= py;
      req_coord_z <= pz;
      req_event_dt <= edt;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      pending_warps.insert(pending_warps.size(), predict_warp(px, py, pz, edt));
   endtask

   task automatic drain_events();
      req_valid <= 1'b0;
      while (pending_warps.size() != 0) @(posedge clock);
      repeat (PIPE_DEPTH + 3) @(posedge clock);
   endtask

   task automatic program_regs(omega_type wx, omega_type wy, omega_type wz, time_type fdt);
      logic [CSR_DATA_WIDTH-1:0] word;
      csr_index_type             idx;
      for (int k = 0; k < 4; k++) begin
         idx = csr_index_type'(k);
         word = CSR_DATA_WIDTH'($urandom());
         case (idx)
            CSR_OMEGA_X: word[OMEGA_WIDTH-1:0] = wx;
            CSR_OMEGA_Y: word[OMEGA_WIDTH-1:0] = wy;
            CSR_OMEGA_Z: word[OMEGA_WIDTH-1:0] = wz;
            CSR_FIXED_DT: word = CSR_DATA_WIDTH'(fdt);
         endcase
         csr_valid <= 1'b1;
         csr_index <= idx;
         csr_data <= word;
         @(posedge clock);
         while (!csr_ready) @(posedge clock);
         case (idx)
            CSR_OMEGA_X: omega_x_q = omega_type'(word[OMEGA_WIDTH-1:0]);
            CSR_OMEGA_Y: omega_y_q = omega_type'(word[OMEGA_WIDTH-1:0]);
            CSR_OMEGA_Z: omega_z_q = omega_type'(word[OMEGA_WIDTH-1:0]);
            CSR_FIXED_DT: fixed_dt_q = time_type'(word[TIME_WIDTH-1:0]);
         endcase
      end
      csr_valid <= 1'b0;
   endtask

   function automatic coord_type rand_coord();
      case ($urandom_range(0, 3))
         0: return coord_type'($urandom());
         1, 2: return coord_type'($urandom_range(0, 8192) - 4096);
         default: begin
            case ($urandom_range(0, 4))
               0: return COORD_POS;
               1: return COORD_NEG;
               2: return coord_type'(4096);
               3: return coord_type'(-4096);
               default: return '0;
            endcase
         end
      endcase
   endfunction

   function automatic time_type rand_dt();
      case ($urandom_range(0, 3))
         0: return time_type'($urandom());
         1: return time_type'($urandom_range(0, 4096));
         2: return time_type'($urandom_range(0, 65535));
         default: return ($urandom_range(0, 1) == 0) ? '0 : DT_MAX;
      endcase
   endfunction

   function automatic omega_type rand_omega();
      case ($urandom_range(0, 3))
         0: return omega_type'($urandom());
         1, 2: return omega_type'($urandom_range(0, 8192) - 4096);
         default: return ($urandom_range(0, 1) == 0) ? omega_type'(32767) : omega_type'(-32768);
      endcase
   endfunction

   // Reset values give zero velocity, so every event must come back unchanged.
   task automatic test_reset_bypass();
      send_event(COORD_POS, COORD_NEG, '0, DT_MAX);
      send_event(COORD_NEG, COORD_POS, COORD_POS, '0);
      send_event(coord_type'(4096), coord_type'(-1), coord_type'(1), time_type'(12345));
      send_event('0, '0, COORD_NEG, DT_MAX);
      drain_events();
   endtask

   task automatic test_field_extremes();
      program_regs(omega_type'(1024), omega_type'(-512), omega_type'(2048), '0);
      send_event(COORD_POS, '0, '0, '0);
      send_event(COORD_POS, '0, '0, DT_MAX);
      send_event(COORD_NEG, COORD_NEG, COORD_NEG, DT_MAX);
      send_event('0, COORD_POS, '0, time_type'(1));
      send_event(coord_type'(4096), coord_type'(-4096), coord_type'(2048), time_type'(524288));
      send_event('0, '0, '0, DT_MAX);
      send_event(coord_type'(-1), coord_type'(1), coord_type'(-1), time_type'(1023));
      drain_events();
   endtask

   // A nonzero fixed warp time must override each event's own offset.
   task automatic test_fixed_warp_time();
      program_regs(omega_type'(-3000), omega_type'(700), omega_type'(1500), DT_MAX);
      send_event(coord_type'(4096), coord_type'(1000), coord_type'(-2000), '0);
      send_event(coord_type'(4096), coord_type'(1000), coord_type'(-2000), time_type'(77));
      send_event(COORD_NEG, COORD_POS, '0, DT_MAX);
      drain_events();
      program_regs(omega_type'(-3000), omega_type'(700), omega_type'(1500), time_type'(1));
      send_event(coord_type'(4096), coord_type'(1000), coord_type'(-2000), DT_MAX);
      drain_events();
   endtask

   task automatic test_saturation();
      program_regs(omega_type'(32767), omega_type'(32767), omega_type'(32767), DT_MAX);
      send_event(COORD_POS, COORD_NEG, '0, '0);
      send_event(COORD_POS, COORD_POS, COORD_POS, '0);
      drain_events();
      program_regs(omega_type'(-32768), omega_type'(-32768), omega_type'(-32768), '0);
      send_event(COORD_NEG, COORD_POS, COORD_NEG, DT_MAX);
      send_event(coord_type'(4096), '0, '0, DT_MAX);
      send_event(coord_type'(4096), '0, '0, '0);
      drain_events();
   endtask

   task automatic test_random_stream();
      omega_type wx;
      omega_type wy;
      omega_type wz;
      time_type  fdt;
      for (int phase = 0; phase < 8; phase++) begin
         wx = rand_omega();
         wy = rand_omega();
         wz = rand_omega();
         fdt = ($urandom_range(0, 2) == 0) ? rand_dt() : '0;
         case (phase)
            0: begin
               wx = omega_type'(32767);
               wy = omega_type'(32767);
               wz = omega_type'(32767);
               fdt = DT_MAX;
            end
            1: begin
               wx = omega_type'(-32768);
               wy = omega_type'(-32768);
               wz = omega_type'(-32768);
               fdt = '0;
            end
            2: begin
               wx = '0;
               wy = '0;
               wz = '0;
            end
            3: begin
               wx = '0;
               wy = '0;
               fdt = time_type'($urandom_range(1, 65535));
            end
            default: ;
         endcase
         program_regs(wx, wy, wz, fdt);
         for (int n = 0; n < 182; n++) begin
            if (n % 60 == 0) idle_enable = ($urandom_range(0, 3) != 0);
            send_event(rand_coord(), rand_coord(), rand_coord(), rand_dt());
         end
         drain_events();
      end
      idle_enable = 1'b1;
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      test_reset_bypass();
      test_field_extremes();
      test_fixed_warp_time();
      test_saturation();
      test_random_stream();
      if (mismatches == 0) begin
         $display("event_rotation_warp_second_order regression: pass");
      end else begin
         $display("event_rotation_warp_second_order regression: fail");
      end
      $finish;
   end

endmodule

FILE: files.f
+incdir+hdl
hdl/erw2_pkg.sv
hdl/erw2_front.sv
hdl/erw2_lane.sv
hdl/event_rotation_warp_second_order.sv
verif/tb_event_rotation_warp_second_order.sv
